// ===== hw/rtl/xbe_pkg.sv =====
// Package for the XTEA block encipher: shared types, widths and cipher constants.
// Used by xbe_cell and xtea_block_encipher; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package xbe_pkg;

  localparam int unsigned XbeMaxRounds = 32;
  localparam int unsigned XbeRoundsW   = 6;
  localparam int unsigned XbeWordW     = 32;
  localparam int unsigned XbeCfgIdxW   = 3;
  localparam logic [31:0] XbeDelta     = 32'h9E37_79B9;

  // Configuration register indexes.
  localparam logic [XbeCfgIdxW-1:0] CfgRounds = 3'd0;
  localparam logic [XbeCfgIdxW-1:0] CfgKey0   = 3'd1;
  localparam logic [XbeCfgIdxW-1:0] CfgKey1   = 3'd2;
  localparam logic [XbeCfgIdxW-1:0] CfgKey2   = 3'd3;
  localparam logic [XbeCfgIdxW-1:0] CfgKey3   = 3'd4;

  typedef logic [3:0][XbeWordW-1:0] xbe_key_t;

  typedef struct packed {
    logic [XbeWordW-1:0] v1;
    logic [XbeWordW-1:0] v0;
  } xbe_blk_t;

endpackage

`default_nettype wire

// ===== hw/rtl/xbe_cell.sv =====
// One XTEA Feistel half-round with its pipeline register.
// Depends on xbe_pkg for the block type, key type and round constant.
`timescale 1ns / 1ps
`default_nettype none

module xbe_cell import xbe_pkg::*; #(
  parameter int unsigned HALF_IDX = 0
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  input  wire xbe_blk_t blk_i,
  input  wire logic     en_i,
  input  wire xbe_key_t key_i,
  output logic          valid_o,
  output xbe_blk_t      blk_o
);

  // Odd cells update v1 after the running sum has advanced; even cells update v0.
  localparam bit          IsSecond = (HALF_IDX % 2) == 1;
  localparam int unsigned SumSteps = (HALF_IDX / 2) + (HALF_IDX % 2);
  localparam logic [63:0] SumFull  = 64'(XbeDelta) * 64'(SumSteps);
  localparam logic [31:0] Sum      = SumFull[31:0];
  localparam logic [1:0]  KeyIdx   = IsSecond ? Sum[12:11] : Sum[1:0];

  logic     valid_q;
  xbe_blk_t blk_d, blk_q;
  logic [XbeWordW-1:0] src, mix, sum_key, upd;

  always_comb begin
    src     = IsSecond ? blk_i.v0 : blk_i.v1;
    mix     = ((src << 4) ^ (src >> 5)) + src;
    sum_key = Sum + key_i[KeyIdx];
    upd     = mix ^ sum_key;
    blk_d   = blk_i;
    if (en_i) begin
      if (IsSecond) begin
        blk_d.v1 = blk_i.v1 + upd;
      end else begin
        blk_d.v0 = blk_i.v0 + upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;

endmodule

`default_nettype wire

// ===== hw/rtl/xtea_block_encipher.sv =====
// Top level of the XTEA block encipher: configuration registers and the cell chain.
// Depends on xbe_pkg and xbe_cell.
`timescale 1ns / 1ps
`default_nettype none

// XTEA encipher for 64-bit blocks. A request is taken on every clock edge at
// which start_i is high; busy_o stays low, so one block can enter every cycle.
// The block passes through a chain of 2*MAX_ROUNDS cells, each doing one
// Feistel half-round and registering the result, so every ciphertext appears
// on cipher_block_o once it has passed the register of every cell, marked
// by a one-cycle pulse on done_o. Results are never held back: the receiver
// must take each one in the cycle it is shown. Cells beyond the programmed
// round count pass the block through unchanged, so the latency does not
// depend on the rounds register; a rounds value above MAX_ROUNDS acts as
// MAX_ROUNDS and zero leaves the block as it was. Bits 31:0 of the block
// form the first half of the cipher state and bits 63:32 the second. The
// key and round count are read live by all cells, so they must only be
// written while no request is still inside the chain.
module xtea_block_encipher import xbe_pkg::*; #(
  parameter int unsigned MAX_ROUNDS = XbeMaxRounds
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [63:0]           plain_block_i,
  output logic                       done_o,
  output logic [63:0]                cipher_block_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [XbeCfgIdxW-1:0] cfg_idx_i,
  input  wire logic [XbeWordW-1:0]   cfg_wdata_i
);

  localparam int unsigned NumCells = 2 * MAX_ROUNDS;

  logic [XbeRoundsW-1:0] rounds_q;
  xbe_key_t              key_q;

  // Configuration writes land immediately; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rounds_q <= XbeRoundsW'(XbeMaxRounds);
      key_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRounds: rounds_q <= cfg_wdata_i[XbeRoundsW-1:0];
        CfgKey0:   key_q[0] <= cfg_wdata_i;
        CfgKey1:   key_q[1] <= cfg_wdata_i;
        CfgKey2:   key_q[2] <= cfg_wdata_i;
        CfgKey3:   key_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so new requests are always welcome.
  assign busy_o = 1'b0;

  logic     valid_chain [NumCells+1];
  xbe_blk_t blk_chain   [NumCells+1];

  assign valid_chain[0] = start_i;
  assign blk_chain[0]   = xbe_blk_t'(plain_block_i);

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    // Both half-rounds of round g/2 run only when that round is below the
    // programmed count; since g/2 never reaches MAX_ROUNDS this also covers
    // the saturation of larger counts.
    logic en;
    assign en = rounds_q > XbeRoundsW'(g / 2);

    xbe_cell #(
      .HALF_IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_chain[g]),
      .blk_i   (blk_chain[g]),
      .en_i    (en),
      .key_i   (key_q),
      .valid_o (valid_chain[g+1]),
      .blk_o   (blk_chain[g+1])
    );
  end

  assign done_o         = valid_chain[NumCells];
  assign cipher_block_o = 64'(blk_chain[NumCells]);

endmodule

`default_nettype wire
